// File: hdl/code_majority_vote_tally_core_macros.svh
// ----------------------------------------------------------------------------
// code majority vote tally assertion macros
// concurrent assertion shorthands, sampled on the rising clock edge and
// disabled while the asynchronous reset is held
// ----------------------------------------------------------------------------
`ifndef CODE_MAJORITY_VOTE_TALLY_CORE_MACROS_SVH
`define CODE_MAJORITY_VOTE_TALLY_CORE_MACROS_SVH

// consequent holds in the same cycle
`define CMVT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the following cycle
`define CMVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/cmvt_pkg.sv
// ----------------------------------------------------------------------------
// code majority vote tally package
// shared constants, sequencer states and the code form check
// ----------------------------------------------------------------------------
package cmvt_pkg;

	localparam int DEF_TABLE_ENTRIES = 8;
	localparam int DEF_COUNT_BITS    = 16;

	localparam int CODE_W       = 48;
	localparam int CODE_CHARS   = 12;
	localparam int HALF_CHARS   = 6;
	localparam int OUT_COUNT_W  = 16;
	localparam int OUT_USED_W   = 4;
	localparam int MIN_VOTES_W  = 8;
	localparam int MARGIN_W     = 4;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOTES     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_FACTOR = 2'd1;

	localparam logic [MIN_VOTES_W-1:0] MIN_VOTES_RST = 8'd2;
	localparam logic [MARGIN_W-1:0]    MARGIN_RST    = 4'd2;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= CH_ZERO) && (ch <= CH_NINE);
	endfunction

	function automatic logic is_upper(input logic [7:0] ch);
		return (ch >= CH_UP_A) && (ch <= CH_UP_Z);
	endfunction

	function automatic logic is_alnum(input logic [7:0] ch);
		return is_digit(ch) || is_upper(ch) || ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z));
	endfunction

	// character 0 sits in the top byte of the high half
	function automatic logic form_ok(input logic [CODE_W-1:0] hi, input logic [CODE_W-1:0] lo);
		logic [7:0] ch;
		logic only_zeros;
		logic ok;
		only_zeros = 1'b1;
		ok = 1'b1;
		for (int i = 0; i < CODE_CHARS; i++) begin
			if (i < HALF_CHARS) begin
				ch = hi[8*(HALF_CHARS-1-i) +: 8];
			end else begin
				ch = lo[8*(CODE_CHARS-1-i) +: 8];
			end
			if (ch != CH_ZERO) begin
				only_zeros = 1'b0;
			end
			if (i < 2) begin
				ok = ok & is_upper(ch);
			end else if (i < 5) begin
				ok = ok & is_alnum(ch);
			end else begin
				ok = ok & is_digit(ch);
			end
		end
		return ok && !only_zeros;
	endfunction

endpackage

// File: hdl/cmvt_ram.sv
// ----------------------------------------------------------------------------
// generic single write, single read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module cmvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/code_majority_vote_tally_core.sv
// ----------------------------------------------------------------------------
// code majority vote tally core
// usage:
// - an item is taken at a rising edge with start high and busy low; it carries
//   the code halves, the usable flag and a flag that first clears the tally
// - min_votes and margin_factor are written through cfg_valid/cfg_ready with
//   cfg_index 0 and 1; cfg_ready is always high, writes belong to idle time
// - every item gives one result, held on the result ports for one cycle with
//   done high; there is no back pressure on results
// - a candidate ram with one read port is walked once to find a match (only
//   for a usable, well-formed code; stops early on a hit) and once to find
//   the leader and runner-up; one item at a time, busy high meanwhile
// - busy drops in the cycle done is high, so the next item may start there
// - reset empties the table and the valid count and restores min_votes 2 and
//   margin_factor 2; ram contents are not cleared, only entries below the
//   fill count are ever read
// ----------------------------------------------------------------------------
`include "code_majority_vote_tally_core_macros.svh"

module code_majority_vote_tally_core #(
	parameter int TABLE_ENTRIES = cmvt_pkg::DEF_TABLE_ENTRIES,
	parameter int COUNT_BITS    = cmvt_pkg::DEF_COUNT_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cmvt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cmvt_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               start,
	output logic                               busy,
	input  logic                               start_new,
	input  logic                               frame_usable,
	input  logic [cmvt_pkg::CODE_W-1:0]        code_high,
	input  logic [cmvt_pkg::CODE_W-1:0]        code_low,
	output logic                               done,
	output logic                               accepted,
	output logic                               dropped_full,
	output logic                               winner_found,
	output logic [cmvt_pkg::CODE_W-1:0]        winner_high,
	output logic [cmvt_pkg::CODE_W-1:0]        winner_low,
	output logic [cmvt_pkg::OUT_COUNT_W-1:0]   winner_votes,
	output logic [cmvt_pkg::OUT_COUNT_W-1:0]   valid_seen,
	output logic [cmvt_pkg::OUT_USED_W-1:0]    entries_in_use
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int RW = 2 * cmvt_pkg::CODE_W + COUNT_BITS;
	localparam int PW = COUNT_BITS + cmvt_pkg::MARGIN_W;
	localparam int OW = (COUNT_BITS > cmvt_pkg::OUT_COUNT_W) ? COUNT_BITS : cmvt_pkg::OUT_COUNT_W;
	localparam int UW = (CW > cmvt_pkg::OUT_USED_W) ? CW : cmvt_pkg::OUT_USED_W;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;
	localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

	cmvt_pkg::state_t state_q, state_d;

	logic [cmvt_pkg::MIN_VOTES_W-1:0] min_votes_q;
	logic [cmvt_pkg::MARGIN_W-1:0]    margin_q;

	logic [cmvt_pkg::CODE_W-1:0] code_hi_q, code_lo_q;
	logic                        acc_q, drop_q;
	logic [CW-1:0]               used_q, ptr_q;
	logic [COUNT_BITS-1:0]       total_q, lead_q, second_q;
	logic [cmvt_pkg::CODE_W-1:0] lead_hi_q, lead_lo_q;
	logic                        rv_s1;
	logic [IW-1:0]               ridx_s1;

	logic                               done_q, out_acc_q, out_drop_q, out_found_q;
	logic [cmvt_pkg::CODE_W-1:0]        out_hi_q, out_lo_q;
	logic [cmvt_pkg::OUT_COUNT_W-1:0]   out_votes_q, out_seen_q;
	logic [cmvt_pkg::OUT_USED_W-1:0]    out_used_q;

	logic                        take, ok_in, pending, full, hit, issue;
	logic                        ins, drop, ram_we;
	logic [IW-1:0]               ram_waddr;
	logic [RW-1:0]               ram_wdata, ram_rdata;
	logic [cmvt_pkg::CODE_W-1:0] rd_hi, rd_lo;
	logic [COUNT_BITS-1:0]       rd_votes, votes_inc, total_base;
	logic [PW-1:0]               margin_prod;
	logic                        found;
	logic [OW-1:0]               lead_ext, total_ext;
	logic [UW-1:0]               used_ext;

	// candidate table: {code high, code low, votes}
	cmvt_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_hi    = ram_rdata[RW-1 -: cmvt_pkg::CODE_W];
	assign rd_lo    = ram_rdata[COUNT_BITS +: cmvt_pkg::CODE_W];
	assign rd_votes = ram_rdata[COUNT_BITS-1:0];
	assign votes_inc = (rd_votes == CMAX) ? rd_votes : rd_votes + COUNT_BITS'(1);

	assign take    = start && (state_q == cmvt_pkg::ST_IDLE);
	assign ok_in   = frame_usable && cmvt_pkg::form_ok(code_high, code_low);
	assign pending = ptr_q < used_q;
	assign full    = used_q == FULL;
	assign hit     = (state_q == cmvt_pkg::ST_MATCH) && rv_s1 &&
		(rd_hi == code_hi_q) && (rd_lo == code_lo_q);
	assign total_base = start_new ? '0 : total_q;

	assign margin_prod = PW'(second_q) * PW'(margin_q);
	assign found = (used_q != '0) && (lead_q >= COUNT_BITS'(min_votes_q)) &&
		((second_q == '0) || (PW'(lead_q) >= margin_prod));

	assign lead_ext  = OW'(lead_q);
	assign total_ext = OW'(total_q);
	assign used_ext  = UW'(used_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cmvt_pkg::ST_IDLE: begin
				if (start) begin
					state_d = ok_in ? cmvt_pkg::ST_MATCH : cmvt_pkg::ST_SCAN;
				end
			end
			cmvt_pkg::ST_MATCH: begin
				if (hit || (!rv_s1 && !pending)) begin
					state_d = cmvt_pkg::ST_SCAN;
				end
			end
			cmvt_pkg::ST_SCAN: begin
				if (!rv_s1 && !pending) begin
					state_d = cmvt_pkg::ST_DECIDE;
				end
			end
			cmvt_pkg::ST_DECIDE: begin
				state_d = cmvt_pkg::ST_IDLE;
			end
			default: begin
				state_d = cmvt_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy  = 1'b1;
		issue = 1'b0;
		ins   = 1'b0;
		drop  = 1'b0;
		case (state_q)
			cmvt_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			cmvt_pkg::ST_MATCH: begin
				issue = pending && !hit;
				ins   = !rv_s1 && !pending && !full;
				drop  = !rv_s1 && !pending && full;
			end
			cmvt_pkg::ST_SCAN: begin
				issue = pending;
			end
			cmvt_pkg::ST_DECIDE: begin
				issue = 1'b0;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
		ram_we    = hit || ins;
		ram_waddr = hit ? ridx_s1 : used_q[IW-1:0];
		ram_wdata = {code_hi_q, code_lo_q, hit ? votes_inc : COUNT_BITS'(1)};
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_votes_q <= cmvt_pkg::MIN_VOTES_RST;
			margin_q    <= cmvt_pkg::MARGIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cmvt_pkg::CFG_MIN_VOTES: begin
					min_votes_q <= cfg_data[cmvt_pkg::MIN_VOTES_W-1:0];
				end
				cmvt_pkg::CFG_MARGIN_FACTOR: begin
					margin_q <= cfg_data[cmvt_pkg::MARGIN_W-1:0];
				end
				default: begin
					min_votes_q <= min_votes_q;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmvt_pkg::ST_IDLE;
			used_q  <= '0;
			total_q <= '0;
			ptr_q   <= '0;
			rv_s1   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= issue;
			done_q  <= state_q == cmvt_pkg::ST_DECIDE;
			if (take) begin
				ptr_q <= '0;
				if (start_new) begin
					used_q <= '0;
				end
				total_q <= (ok_in && (total_base != CMAX)) ?
					total_base + COUNT_BITS'(1) : total_base;
			end else if ((state_q == cmvt_pkg::ST_MATCH) &&
				(state_d == cmvt_pkg::ST_SCAN)) begin
				ptr_q <= '0;
			end else if (issue) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (ins) begin
				used_q <= used_q + CW'(1);
			end
		end
	end

	// item payload and running leader
	always_ff @(posedge clk) begin
		ridx_s1 <= ptr_q[IW-1:0];
		if (take) begin
			code_hi_q <= code_high;
			code_lo_q <= code_low;
			acc_q     <= ok_in;
			drop_q    <= 1'b0;
			lead_q    <= '0;
			second_q  <= '0;
			lead_hi_q <= '0;
			lead_lo_q <= '0;
		end
		if (drop) begin
			drop_q <= 1'b1;
		end
		if ((state_q == cmvt_pkg::ST_SCAN) && rv_s1) begin
			if (rd_votes > lead_q) begin
				second_q  <= lead_q;
				lead_q    <= rd_votes;
				lead_hi_q <= rd_hi;
				lead_lo_q <= rd_lo;
			end else if (rd_votes > second_q) begin
				second_q <= rd_votes;
			end
		end
		if (state_q == cmvt_pkg::ST_DECIDE) begin
			out_acc_q   <= acc_q;
			out_drop_q  <= drop_q;
			out_found_q <= found;
			out_hi_q    <= found ? lead_hi_q : '0;
			out_lo_q    <= found ? lead_lo_q : '0;
			out_votes_q <= lead_ext[cmvt_pkg::OUT_COUNT_W-1:0];
			out_seen_q  <= total_ext[cmvt_pkg::OUT_COUNT_W-1:0];
			out_used_q  <= used_ext[cmvt_pkg::OUT_USED_W-1:0];
		end
	end

	assign done           = done_q;
	assign accepted       = out_acc_q;
	assign dropped_full   = out_drop_q;
	assign winner_found   = out_found_q;
	assign winner_high    = out_hi_q;
	assign winner_low     = out_lo_q;
	assign winner_votes   = out_votes_q;
	assign valid_seen     = out_seen_q;
	assign entries_in_use = out_used_q;

	`CMVT_ASSERT_NEXT(a_take_busy, clk, arst_n, start && !busy, busy && !done, "item transfer did not start the sequencer")
	`CMVT_ASSERT_NEXT(a_decide_done, clk, arst_n, state_q == cmvt_pkg::ST_DECIDE, done && !busy, "decision not followed by a result")
	`CMVT_ASSERT_SAME(a_fill_bound, clk, arst_n, 1'b1, used_q <= FULL, "fill count beyond table size")
	`CMVT_ASSERT_SAME(a_write_match, clk, arst_n, ram_we, (state_q == cmvt_pkg::ST_MATCH) && acc_q, "table written outside the match walk")
	`CMVT_ASSERT_SAME(a_drop_full, clk, arst_n, done && dropped_full, accepted && (used_q == FULL), "drop reported with a free entry")

endmodule

// File: tb/sv/tb_code_majority_vote_tally_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code majority vote tally core testbench
// drives recording codes through the start/busy command port and checks each
// done strobe against an in-bench tally model: a short directed table, then
// random vote sessions under several threshold settings, then a final
// stretch of sessions with no idle cycles
// ----------------------------------------------------------------------------
module tb_code_majority_vote_tally_core;

	localparam int TABLE_N      = cmvt_pkg::DEF_TABLE_ENTRIES;
	localparam int COUNT_SAT    = (1 << cmvt_pkg::DEF_COUNT_BITS) - 1;
	localparam int CYCLE_LIMIT  = 200_000;
	localparam int IDLE_SETTLE  = 2 * cmvt_pkg::DEF_TABLE_ENTRIES + 8;
	localparam int MAX_REPORTS  = 10;

	localparam logic [cmvt_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [cmvt_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	localparam logic [cmvt_pkg::CODE_W-1:0] A_HI = "AB12c3";
	localparam logic [cmvt_pkg::CODE_W-1:0] A_LO = "456789";

	typedef struct packed {
		logic                             acc;
		logic                             drop;
		logic                             found;
		logic [cmvt_pkg::CODE_W-1:0]      w_hi;
		logic [cmvt_pkg::CODE_W-1:0]      w_lo;
		logic [cmvt_pkg::OUT_COUNT_W-1:0] w_votes;
		logic [cmvt_pkg::OUT_COUNT_W-1:0] v_seen;
		logic [cmvt_pkg::OUT_USED_W-1:0]  used;
	} tally_res_t;

	typedef struct {
		bit                          sn;
		bit                          fu;
		logic [cmvt_pkg::CODE_W-1:0] hi;
		logic [cmvt_pkg::CODE_W-1:0] lo;
		bit                          typed;
		tally_res_t                  res;
	} frame_row_t;

	localparam tally_res_t NO_TALLY = '0;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [cmvt_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [cmvt_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                             start;
	logic                             busy;
	logic                             start_new;
	logic                             frame_usable;
	logic [cmvt_pkg::CODE_W-1:0]      code_high;
	logic [cmvt_pkg::CODE_W-1:0]      code_low;
	logic                             done;
	logic                             accepted;
	logic                             dropped_full;
	logic                             winner_found;
	logic [cmvt_pkg::CODE_W-1:0]      winner_high;
	logic [cmvt_pkg::CODE_W-1:0]      winner_low;
	logic [cmvt_pkg::OUT_COUNT_W-1:0] winner_votes;
	logic [cmvt_pkg::OUT_COUNT_W-1:0] valid_seen;
	logic [cmvt_pkg::OUT_USED_W-1:0]  entries_in_use;

	// tally model state
	logic [cmvt_pkg::CODE_W-1:0] cand_hi [TABLE_N];
	logic [cmvt_pkg::CODE_W-1:0] cand_lo [TABLE_N];
	int                          cand_votes [TABLE_N];
	int                          cand_used;
	int                          valid_cnt;
	int                          min_votes_q;
	int                          margin_q;

	tally_res_t pending_tallies [$];
	frame_row_t directed_rows [$];
	tally_res_t got_tally;
	tally_res_t want_tally;
	int         mismatches;
	int         idle_pct;
	bit         idle_allowed;

	code_majority_vote_tally_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.start_new      (start_new),
		.frame_usable   (frame_usable),
		.code_high      (code_high),
		.code_low       (code_low),
		.done           (done),
		.accepted       (accepted),
		.dropped_full   (dropped_full),
		.winner_found   (winner_found),
		.winner_high    (winner_high),
		.winner_low     (winner_low),
		.winner_votes   (winner_votes),
		.valid_seen     (valid_seen),
		.entries_in_use (entries_in_use)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_code_majority_vote_tally_core: done, errors");
		$finish;
	end

	function automatic bit code_form_valid(input logic [cmvt_pkg::CODE_W-1:0] hi,
			input logic [cmvt_pkg::CODE_W-1:0] lo);
		logic [2*cmvt_pkg::CODE_W-1:0] code;
		logic [7:0]                    ch;
		bit                            ok;
		bit                            zeros;
		bit                            up_c;
		bit                            dig_c;
		bit                            low_c;
		code  = {hi, lo};
		ok    = 1'b1;
		zeros = 1'b1;
		for (int i = 0; i < cmvt_pkg::CODE_CHARS; i++) begin
			ch    = code[2*cmvt_pkg::CODE_W-1-8*i -: 8];
			up_c  = (ch >= "A") && (ch <= "Z");
			dig_c = (ch >= "0") && (ch <= "9");
			low_c = (ch >= "a") && (ch <= "z");
			if (ch != "0") begin
				zeros = 1'b0;
			end
			if (i < 2) begin
				ok = ok && up_c;
			end else if (i < 5) begin
				ok = ok && (up_c || dig_c || low_c);
			end else begin
				ok = ok && dig_c;
			end
		end
		return ok && !zeros;
	endfunction

	function automatic tally_res_t tally_step(input bit sn, input bit fu,
			input logic [cmvt_pkg::CODE_W-1:0] hi, input logic [cmvt_pkg::CODE_W-1:0] lo);
		tally_res_t r;
		bit         hit;
		int         lead_i;
		int         lead;
		int         second;
		r = NO_TALLY;
		if (sn) begin
			cand_used = 0;
			valid_cnt = 0;
		end
		if (fu && code_form_valid(hi, lo)) begin
			r.acc = 1'b1;
			if (valid_cnt < COUNT_SAT) begin
				valid_cnt++;
			end
			hit = 1'b0;
			for (int i = 0; i < cand_used && !hit; i++) begin
				if (cand_hi[i] == hi && cand_lo[i] == lo) begin
					if (cand_votes[i] < COUNT_SAT) begin
						cand_votes[i]++;
					end
					hit = 1'b1;
				end
			end
			if (!hit) begin
				if (cand_used < TABLE_N) begin
					cand_hi[cand_used]    = hi;
					cand_lo[cand_used]    = lo;
					cand_votes[cand_used] = 1;
					cand_used++;
				end else begin
					r.drop = 1'b1;
				end
			end
		end
		if (cand_used > 0) begin
			lead_i = 0;
			lead   = cand_votes[0];
			for (int i = 1; i < cand_used; i++) begin
				if (cand_votes[i] > lead) begin
					lead   = cand_votes[i];
					lead_i = i;
				end
			end
			second = 0;
			for (int i = 0; i < cand_used; i++) begin
				if (i != lead_i && cand_votes[i] > second) begin
					second = cand_votes[i];
				end
			end
			r.w_votes = lead[cmvt_pkg::OUT_COUNT_W-1:0];
			if (lead >= min_votes_q && (second == 0 || lead >= margin_q * second)) begin
				r.found = 1'b1;
				r.w_hi  = cand_hi[lead_i];
				r.w_lo  = cand_lo[lead_i];
			end
		end
		r.v_seen = valid_cnt[cmvt_pkg::OUT_COUNT_W-1:0];
		r.used   = cand_used[cmvt_pkg::OUT_USED_W-1:0];
		return r;
	endfunction

	function automatic logic [2*cmvt_pkg::CODE_W-1:0] rand_valid_code();
		logic [2*cmvt_pkg::CODE_W-1:0] c;
		int                            r;
		for (int i = 0; i < cmvt_pkg::CODE_CHARS; i++) begin
			if (i < 2) begin
				c[2*cmvt_pkg::CODE_W-1-8*i -: 8] = 8'("A" + $urandom_range(0, 25));
			end else if (i < 5) begin
				r = $urandom_range(0, 61);
				if (r < 10) begin
					c[2*cmvt_pkg::CODE_W-1-8*i -: 8] = 8'("0" + r);
				end else if (r < 36) begin
					c[2*cmvt_pkg::CODE_W-1-8*i -: 8] = 8'("A" + r - 10);
				end else begin
					c[2*cmvt_pkg::CODE_W-1-8*i -: 8] = 8'("a" + r - 36);
				end
			end else begin
				c[2*cmvt_pkg::CODE_W-1-8*i -: 8] = 8'("0" + $urandom_range(0, 9));
			end
		end
		return c;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			got_tally = {accepted, dropped_full, winner_found, winner_high, winner_low,
				winner_votes, valid_seen, entries_in_use};
			if (pending_tallies.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("result with nothing pending: acc=%0d drop=%0d found=%0d",
						got_tally.acc, got_tally.drop, got_tally.found);
				end
			end else begin
				want_tally = pending_tallies.pop_front();
				if (got_tally.acc !== want_tally.acc || got_tally.drop !== want_tally.drop ||
						got_tally.found !== want_tally.found ||
						got_tally.w_hi !== want_tally.w_hi || got_tally.w_lo !== want_tally.w_lo ||
						got_tally.w_votes !== want_tally.w_votes ||
						got_tally.v_seen !== want_tally.v_seen ||
						got_tally.used !== want_tally.used) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("mismatch exp: acc=%0d drop=%0d found=%0d win=%h_%h votes=%0d seen=%0d used=%0d",
							want_tally.acc, want_tally.drop, want_tally.found, want_tally.w_hi,
							want_tally.w_lo, want_tally.w_votes, want_tally.v_seen, want_tally.used);
						$display("         got: acc=%0d drop=%0d found=%0d win=%h_%h votes=%0d seen=%0d used=%0d",
							got_tally.acc, got_tally.drop, got_tally.found, got_tally.w_hi,
							got_tally.w_lo, got_tally.w_votes, got_tally.v_seen, got_tally.used);
					end
				end
			end
		end
	end

	task automatic issue_frame(input bit sn, input bit fu, input logic [cmvt_pkg::CODE_W-1:0] hi,
			input logic [cmvt_pkg::CODE_W-1:0] lo, input bit typed, input tally_res_t res,
			output bit counted);
		int         gap;
		tally_res_t pred;
		gap = 0;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 18);
		end
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start        = 1'b1;
		start_new    = sn;
		frame_usable = fu;
		code_high    = hi;
		code_low     = lo;
		do @(posedge clk); while (busy !== 1'b0);
		pred    = tally_step(sn, fu, hi, lo);
		counted = pred.acc;
		pending_tallies.push_back(typed ? res : pred);
	endtask

	task automatic add_row(input bit sn, input bit fu, input logic [cmvt_pkg::CODE_W-1:0] hi,
			input logic [cmvt_pkg::CODE_W-1:0] lo, input bit typed, input tally_res_t res);
		frame_row_t row;
		row.sn    = sn;
		row.fu    = fu;
		row.hi    = hi;
		row.lo    = lo;
		row.typed = typed;
		row.res   = res;
		directed_rows.push_back(row);
	endtask

	task automatic wait_tally_idle();
		@(negedge clk);
		start = 1'b0;
		while (pending_tallies.size() != 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic set_tally_reg(input logic [cmvt_pkg::CFG_IDX_W-1:0] idx,
			input logic [cmvt_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		start     = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == cmvt_pkg::CFG_MIN_VOTES) begin
			min_votes_q = val;
		end else if (idx == cmvt_pkg::CFG_MARGIN_FACTOR) begin
			margin_q = val[cmvt_pkg::MARGIN_W-1:0];
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(input logic [cmvt_pkg::CFG_DATA_W-1:0] min_v,
			input logic [cmvt_pkg::CFG_DATA_W-1:0] margin_v);
		wait_tally_idle();
		set_tally_reg(cmvt_pkg::CFG_MIN_VOTES, min_v);
		set_tally_reg(cmvt_pkg::CFG_MARGIN_FACTOR, margin_v);
	endtask

	// vote sessions: each opens with a clear and draws mostly from a small pool
	task automatic run_vote_sessions(input int target, input int sess_max);
		logic [2*cmvt_pkg::CODE_W-1:0] pool [10];
		logic [2*cmvt_pkg::CODE_W-1:0] c;
		int                            counted;
		int                            sess_left;
		int                            pool_n;
		int                            lead_pct;
		int                            kind;
		int                            pick;
		int                            pos;
		bit                            sn;
		bit                            fu;
		bit                            cnt;
		counted   = 0;
		sess_left = 0;
		pool_n    = 1;
		lead_pct  = 50;
		while (counted < target) begin
			sn = 1'b0;
			if (sess_left == 0) begin
				sn        = 1'b1;
				sess_left = $urandom_range(10, sess_max);
				pool_n    = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 5);
				for (int i = 0; i < pool_n; i++) begin
					pool[i] = rand_valid_code();
				end
				lead_pct = $urandom_range(40, 95);
				if (idle_allowed) begin
					case ($urandom_range(0, 2))
						0: idle_pct = 0;
						1: idle_pct = 15;
						default: idle_pct = 50;
					endcase
				end
			end else if ($urandom_range(0, 99) == 0) begin
				sn = 1'b1;
			end
			sess_left--;
			fu   = 1'b1;
			kind = $urandom_range(0, 99);
			pick = ($urandom_range(0, 99) < lead_pct) ? 0 : $urandom_range(0, pool_n - 1);
			if (kind < 70) begin
				c = pool[pick];
			end else if (kind < 78) begin
				c = rand_valid_code();
			end else if (kind < 84) begin
				c      = pool[pick];
				pos    = $urandom_range(0, 2 * cmvt_pkg::CODE_W - 1);
				c[pos] = ~c[pos];
			end else if (kind < 90) begin
				c = pool[pick];
				pos = $urandom_range(0, cmvt_pkg::CODE_CHARS - 1);
				c[8*pos +: 8] = 8'($urandom);
			end else if (kind < 94) begin
				c = {$urandom, $urandom, $urandom};
			end else if (kind < 97) begin
				c = {cmvt_pkg::CODE_CHARS{"0"}};
			end else begin
				fu = 1'b0;
				c  = {$urandom, $urandom, $urandom};
			end
			issue_frame(sn, fu, c[2*cmvt_pkg::CODE_W-1:cmvt_pkg::CODE_W], c[cmvt_pkg::CODE_W-1:0],
				1'b0, NO_TALLY, cnt);
			if (cnt) begin
				counted++;
			end
		end
	endtask

	initial begin
		bit cnt;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = cmvt_pkg::CFG_MIN_VOTES;
		cfg_data     = '0;
		start        = 1'b0;
		start_new    = 1'b0;
		frame_usable = 1'b0;
		code_high    = '0;
		code_low     = '0;
		mismatches   = 0;
		idle_pct     = 0;
		idle_allowed = 1'b1;
		cand_used    = 0;
		valid_cnt    = 0;
		min_votes_q  = cmvt_pkg::MIN_VOTES_RST;
		margin_q     = cmvt_pkg::MARGIN_RST;
		for (int i = 0; i < TABLE_N; i++) begin
			cand_hi[i]    = '0;
			cand_lo[i]    = '0;
			cand_votes[i] = 0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		add_row(1'b0, 1'b0, '1, '0, 1'b1, NO_TALLY);
		add_row(1'b0, 1'b1, "000000", "000000", 1'b1, NO_TALLY);
		add_row(1'b0, 1'b1, '1, '1, 1'b1, NO_TALLY);
		add_row(1'b0, 1'b1, '0, '0, 1'b1, NO_TALLY);
		add_row(1'b0, 1'b1, A_HI, A_LO, 1'b1,
			'{1'b1, 1'b0, 1'b0, 48'h0, 48'h0, 16'd1, 16'd1, 4'd1});
		add_row(1'b0, 1'b1, A_HI, A_LO, 1'b1,
			'{1'b1, 1'b0, 1'b1, A_HI, A_LO, 16'd2, 16'd2, 4'd1});
		add_row(1'b0, 1'b0, A_HI, A_LO, 1'b0, NO_TALLY);
		add_row(1'b0, 1'b1, "@B12c3", A_LO, 1'b0, NO_TALLY);
		add_row(1'b0, 1'b1, "A[12c3", A_LO, 1'b0, NO_TALLY);
		add_row(1'b0, 1'b1, "AB/2c3", A_LO, 1'b0, NO_TALLY);
		add_row(1'b0, 1'b1, "AB1`c3", A_LO, 1'b0, NO_TALLY);
		add_row(1'b0, 1'b1, "AB12{3", A_LO, 1'b0, NO_TALLY);
		add_row(1'b0, 1'b1, "AB12cA", A_LO, 1'b0, NO_TALLY);
		add_row(1'b0, 1'b1, A_HI, "45678:", 1'b0, NO_TALLY);
		add_row(1'b0, 1'b1, "ZA0zZ9", "000000", 1'b0, NO_TALLY);
		add_row(1'b0, 1'b1, "AZa9z0", "999999", 1'b0, NO_TALLY);
		add_row(1'b0, 1'b1, A_HI, "456788", 1'b0, NO_TALLY);
		add_row(1'b1, 1'b0, A_HI, A_LO, 1'b1, NO_TALLY);
		add_row(1'b1, 1'b1, A_HI, A_LO, 1'b1,
			'{1'b1, 1'b0, 1'b0, 48'h0, 48'h0, 16'd1, 16'd1, 4'd1});
		for (int i = 0; i < TABLE_N - 1; i++) begin
			add_row(1'b0, 1'b1, {"B", 8'("A" + i), "000", 8'("1" + i)},
				{8'("1" + i), "00000"}, 1'b0, NO_TALLY);
		end
		add_row(1'b0, 1'b1, "BH0008", "800000", 1'b1,
			'{1'b1, 1'b1, 1'b0, 48'h0, 48'h0, 16'd1, 16'd9, 4'd8});
		add_row(1'b0, 1'b1, A_HI, A_LO, 1'b0, NO_TALLY);
		foreach (directed_rows[i]) begin
			issue_frame(directed_rows[i].sn, directed_rows[i].fu, directed_rows[i].hi,
				directed_rows[i].lo, directed_rows[i].typed, directed_rows[i].res, cnt);
		end

		// random sessions across threshold settings
		configure(8'd1, 8'd1);
		run_vote_sessions(110, 80);
		configure(8'd255, 8'd8);
		run_vote_sessions(90, 300);
		configure(8'd0, 8'd0);
		run_vote_sessions(90, 80);
		configure(8'd3, 8'hF5);
		set_tally_reg(CFG_SPARE_2, 8'hFF);
		set_tally_reg(CFG_SPARE_3, 8'hA5);
		run_vote_sessions(100, 80);
		configure(8'd2, 8'd2);
		run_vote_sessions(110, 80);
		for (int k = 0; k < 2; k++) begin
			configure(8'($urandom_range(1, 12)), 8'($urandom_range(1, 8)));
			run_vote_sessions(55, 80);
		end

		// last part with no idling
		idle_allowed = 1'b0;
		idle_pct     = 0;
		configure(8'd1, 8'd8);
		run_vote_sessions(120, 80);

		wait_tally_idle();
		repeat (IDLE_SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_code_majority_vote_tally_core: done, clean");
		end else begin
			$display("tb_code_majority_vote_tally_core: done, errors");
		end
		$finish;
	end

endmodule
